FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define QRIM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qrim assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define QRIM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qrim assertion failed");

`endif

FILE: design/qrim_pkg.sv
// ----------------------------------------------------------------------------
// qrim_pkg
// Widths, constants, state types and helpers of the quarter-rate I/Q
// demodulator with magnitude estimate.
// ----------------------------------------------------------------------------
package qrim_pkg;

	// Field widths of the channels
	localparam int SAMPLE_W   = 10;
	localparam int SUM_OUT_W  = 16;
	localparam int MAG_W      = 11;
	localparam int WINDOW_W   = 7;

	// Sizing of the datapath
	localparam int SAMPLE_BITS = 10;
	localparam int MAX_GROUPS  = 64;
	localparam int PRE_SHIFT   = 3;
	localparam int POST_SHIFT  = 8;
	localparam int ACC_W       = SAMPLE_BITS + 2 + $clog2(MAX_GROUPS);
	localparam int T_W         = ACC_W - PRE_SHIFT;
	localparam int SUM_W       = 2 * T_W;
	localparam int X_W         = SUM_W - POST_SHIFT;
	localparam int LEN_W       = $clog2(X_W + 1);
	localparam int K_W         = LEN_W - 1;

	// Limits and reset values
	localparam int SUM_LIMIT    = 32736;
	localparam int MAG_LIMIT    = 2047;
	localparam int WINDOW_RESET = 32;

	// Configuration port
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	// Mixer phase codes
	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;
	localparam logic [1:0] PH_3 = 2'd3;

	typedef enum logic [1:0] {
		TS_RUN,
		TS_MAG,
		TS_HOLD
	} top_state_t;

	typedef enum logic [2:0] {
		MG_IDLE,
		MG_SQ_I,
		MG_SQ_Q,
		MG_NORM,
		MG_LEN,
		MG_ROOT,
		MG_DONE
	} mag_state_t;

	// Status of the magnitude unit toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} mag_stat_t;

	// Clamp a running sum to the output field range
	function automatic logic signed [SUM_OUT_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] lim;
		lim = ACC_W'(SUM_LIMIT);
		if (v > lim) begin
			return SUM_OUT_W'(SUM_LIMIT);
		end else if (v < -lim) begin
			return -SUM_OUT_W'(SUM_LIMIT);
		end
		return v[SUM_OUT_W-1:0];
	endfunction

	// Clamp the window register to 1..MAX_GROUPS
	function automatic logic [WINDOW_W-1:0] eff_window(input logic [WINDOW_W-1:0] w);
		if (w == '0) begin
			return WINDOW_W'(1);
		end else if (w > WINDOW_W'(MAX_GROUPS)) begin
			return WINDOW_W'(MAX_GROUPS);
		end
		return w;
	endfunction

endpackage

FILE: design/qrim_if.sv
// ----------------------------------------------------------------------------
// qrim channel interfaces
// Valid/ready channels for ADC samples in and window results out.
// ----------------------------------------------------------------------------
interface qrim_in_if;
	import qrim_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface qrim_out_if;
	import qrim_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [SUM_OUT_W-1:0] in_phase_sum;
	logic signed [SUM_OUT_W-1:0] quadrature_sum;
	logic [MAG_W-1:0]            magnitude;

	modport source (output valid, output in_phase_sum, output quadrature_sum,
		output magnitude, input ready);
	modport sink (input valid, input in_phase_sum, input quadrature_sum,
		input magnitude, output ready);
endinterface

FILE: design/qrim_regs.sv
// ----------------------------------------------------------------------------
// qrim_regs
// APB-style register file holding the window length.
// ----------------------------------------------------------------------------
module qrim_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qrim_pkg::PADDR_W-1:0] paddr,
	input  logic [qrim_pkg::PDATA_W-1:0] pwdata,
	output logic [qrim_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output logic [qrim_pkg::WINDOW_W-1:0] window_groups
);
	import qrim_pkg::*;

	logic [WINDOW_W-1:0] window_q;
	logic                wr_en;

	// Single register: every word address of the port decodes to it
	assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1:0] == paddr);
	assign pready = 1'b1;

	// Write the window length on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_W'(WINDOW_RESET);
		end else if (wr_en) begin
			window_q <= pwdata[WINDOW_W-1:0];
		end
	end

	assign prdata        = PDATA_W'(window_q);
	assign window_groups = window_q;

endmodule

FILE: design/qrim_mag.sv
// ----------------------------------------------------------------------------
// qrim_mag
// Iterative magnitude unit: one shared multiplier squares both scaled sums,
// a one-bit-per-cycle scan finds the bit length, and a single Newton step
// from a power-of-two guess gives the root.
// ----------------------------------------------------------------------------
module qrim_mag (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [qrim_pkg::ACC_W-1:0] acc_i,
	input  logic signed [qrim_pkg::ACC_W-1:0] acc_q,
	output qrim_pkg::mag_stat_t               stat,
	output logic [qrim_pkg::MAG_W-1:0]        magnitude
);
	import qrim_pkg::*;

	mag_state_t state_q, state_d;

	logic signed [T_W-1:0]   ti_q, tq_q;
	logic signed [T_W-1:0]   mul_op;
	logic signed [SUM_W-1:0] prod;
	logic [SUM_W-1:0]        sum_q;
	logic [X_W-1:0]          x_q, scan_q;
	logic [LEN_W-1:0]        len_q;
	logic [MAG_W-1:0]        mag_q;
	logic [K_W-1:0]          half_len;
	logic [X_W:0]            guess, quot, newton;
	logic [X_W-1:0]          root;
	logic [MAG_W-1:0]        root_sat;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MG_IDLE: if (start) begin
				state_d = MG_SQ_I;
			end
			MG_SQ_I: state_d = MG_SQ_Q;
			MG_SQ_Q: state_d = MG_NORM;
			MG_NORM: state_d = MG_LEN;
			MG_LEN: if (scan_q == '0) begin
				state_d = MG_ROOT;
			end
			MG_ROOT: state_d = MG_DONE;
			MG_DONE: state_d = MG_IDLE;
			default: state_d = MG_IDLE;
		endcase
	end

	// Status outputs
	always_comb begin
		stat.busy = (state_q != MG_IDLE);
		stat.done = (state_q == MG_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Shared squaring multiplier
	assign mul_op = (state_q == MG_SQ_Q) ? tq_q : ti_q;
	assign prod   = SUM_W'(mul_op) * SUM_W'(mul_op);

	// Newton step from the power-of-two guess; x/s is a shift
	assign half_len = len_q[LEN_W-1:1];
	assign guess    = (X_W+1)'(1) << half_len;
	assign quot     = {1'b0, x_q} >> half_len;
	assign newton   = guess + quot;
	assign root     = newton[X_W:1];
	assign root_sat = (root > X_W'(MAG_LIMIT)) ? MAG_W'(MAG_LIMIT) : root[MAG_W-1:0];

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			MG_IDLE: if (start) begin
				ti_q <= T_W'(acc_i >>> PRE_SHIFT);
				tq_q <= T_W'(acc_q >>> PRE_SHIFT);
			end
			MG_SQ_I: sum_q <= prod;
			MG_SQ_Q: sum_q <= sum_q + prod;
			MG_NORM: begin
				x_q    <= sum_q[SUM_W-1:POST_SHIFT];
				scan_q <= sum_q[SUM_W-1:POST_SHIFT];
				len_q  <= '0;
			end
			MG_LEN: if (scan_q != '0) begin
				scan_q <= scan_q >> 1;
				len_q  <= len_q + LEN_W'(1);
			end
			MG_ROOT: mag_q <= (x_q == '0) ? '0 : root_sat;
			MG_DONE: ;
			default: ;
		endcase
	end

	assign magnitude = mag_q;

endmodule

FILE: design/quarter_rate_iq_magnitude.sv
// ----------------------------------------------------------------------------
// quarter_rate_iq_magnitude
// Quarter-rate I/Q mixer and accumulator with a windowed magnitude estimate.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while no window closes.
// The sample that closes a window holds off input while the magnitude unit squares,
// scans the bit length and takes the root; the result is valid when input resumes.
// Input also waits while a finished result cannot enter a full output register.
// Reset clears sums, phase and group count and sets the window to 32 groups.
module quarter_rate_iq_magnitude (
	input  logic                         clk,
	input  logic                         arst_n,
	qrim_in_if.sink                      in_ch,
	qrim_out_if.source                   out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qrim_pkg::PADDR_W-1:0] paddr,
	input  logic [qrim_pkg::PDATA_W-1:0] pwdata,
	output logic [qrim_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import qrim_pkg::*;
	`include "assert_macros.svh"

	top_state_t state_q, state_d;

	logic [WINDOW_W-1:0]         window_groups;
	logic [WINDOW_W-1:0]         eff;
	logic signed [ACC_W-1:0]     acc_i_q, acc_q_q;
	logic signed [ACC_W-1:0]     acc_i_d, acc_q_d, samp;
	logic [1:0]                  phase_q;
	logic [WINDOW_W-1:0]         group_q;
	logic                        accept, win_end, slot_free, load;
	logic signed [SUM_OUT_W-1:0] pend_i_q, pend_q_q;
	logic                        out_valid_q;
	logic signed [SUM_OUT_W-1:0] out_i_q, out_q_q;
	logic [MAG_W-1:0]            out_mag_q;
	logic [MAG_W-1:0]            mag_value;
	mag_stat_t                   mag_stat;

	qrim_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.window_groups (window_groups)
	);

	qrim_mag u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && win_end),
		.acc_i     (acc_i_d),
		.acc_q     (acc_q_d),
		.stat      (mag_stat),
		.magnitude (mag_value)
	);

	// Mix the sample into both sums
	assign samp = ACC_W'(in_ch.sample[SAMPLE_BITS-1:0]);
	always_comb begin
		unique case (phase_q)
			PH_0: begin
				acc_i_d = acc_i_q + samp;
				acc_q_d = acc_q_q + samp;
			end
			PH_1: begin
				acc_i_d = acc_i_q - samp;
				acc_q_d = acc_q_q + samp;
			end
			PH_2: begin
				acc_i_d = acc_i_q - samp;
				acc_q_d = acc_q_q - samp;
			end
			PH_3: begin
				acc_i_d = acc_i_q + samp;
				acc_q_d = acc_q_q - samp;
			end
			default: begin
				acc_i_d = acc_i_q;
				acc_q_d = acc_q_q;
			end
		endcase
	end

	assign eff       = eff_window(window_groups);
	assign win_end   = (phase_q == PH_3) && ((group_q + WINDOW_W'(1)) >= eff);
	assign accept    = in_ch.valid && in_ch.ready;
	assign slot_free = !out_valid_q || out_ch.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_RUN: if (accept && win_end) begin
				state_d = TS_MAG;
			end
			TS_MAG: if (mag_stat.done) begin
				state_d = slot_free ? TS_RUN : TS_HOLD;
			end
			TS_HOLD: if (slot_free) begin
				state_d = TS_RUN;
			end
			default: state_d = TS_RUN;
		endcase
	end

	// Handshake and load controls
	always_comb begin
		in_ch.ready = (state_q == TS_RUN);
		load        = ((state_q == TS_MAG && mag_stat.done) || state_q == TS_HOLD)
			&& slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance sums, phase and group count; clear them at window end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_i_q <= '0;
			acc_q_q <= '0;
			phase_q <= PH_0;
			group_q <= '0;
		end else if (accept) begin
			if (win_end) begin
				acc_i_q <= '0;
				acc_q_q <= '0;
				group_q <= '0;
			end else begin
				acc_i_q <= acc_i_d;
				acc_q_q <= acc_q_d;
				if (phase_q == PH_3) begin
					group_q <= group_q + WINDOW_W'(1);
				end
			end
			phase_q <= phase_q + 2'd1;
		end
	end

	// Hold the clamped sums until the magnitude is ready
	always_ff @(posedge clk) begin
		if (accept && win_end) begin
			pend_i_q <= sat_sum(acc_i_d);
			pend_q_q <= sat_sum(acc_q_d);
		end
	end

	// Output register: drop on ready, load a finished result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_i_q   <= pend_i_q;
			out_q_q   <= pend_q_q;
			out_mag_q <= mag_value;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.in_phase_sum   = out_i_q;
	assign out_ch.quadrature_sum = out_q_q;
	assign out_ch.magnitude      = out_mag_q;

	`QRIM_ASSERT_IMP(a_busy_blocks_input, clk, arst_n, mag_stat.busy, !in_ch.ready)
	`QRIM_ASSERT_IMP(a_done_only_in_mag, clk, arst_n, mag_stat.done, state_q == TS_MAG)
	`QRIM_ASSERT_NXT(a_window_clears, clk, arst_n, accept && win_end,
		acc_i_q == '0 && acc_q_q == '0 && group_q == '0 && phase_q == PH_0)
	`QRIM_ASSERT_NXT(a_load_sets_valid, clk, arst_n, load, out_valid_q)

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quarter-rate I/Q demodulator. ADC samples are
// streamed in over valid/ready with random gaps and output stalls. A local
// mixer and magnitude predictor builds each expected window result, and every
// result beat is checked field by field. The window register goes through
// zero, one, 64, out-of-range values and random settings over the APB port.
// ----------------------------------------------------------------------------
module testbench;
	import qrim_pkg::*;

	localparam int                 HALF_PERIOD  = 10;
	localparam int                 RESET_CYCLES = 7;
	localparam int                 SETTLE       = 40;
	localparam int                 CYCLE_LIMIT  = 600000;
	localparam int                 ITEM_TARGET  = 1950;
	localparam logic [PADDR_W-1:0] WINDOW_ADDR  = '0;

	typedef enum {SRC_NOISE, SRC_TONE, SRC_SQUARE} source_kind_t;

	typedef struct {
		logic signed [SUM_OUT_W-1:0] in_phase_sum;
		logic signed [SUM_OUT_W-1:0] quadrature_sum;
		logic [MAG_W-1:0]            magnitude;
	} window_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	qrim_in_if  in_bus ();
	qrim_out_if out_bus ();

	quarter_rate_iq_magnitude dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_bus),
		.out_ch  (out_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state
	logic [WINDOW_W-1:0] window_reg;
	int                  acc_i;
	int                  acc_q;
	logic [1:0]          mix_phase;
	logic [WINDOW_W-1:0] group_count;

	logic [SAMPLE_W-1:0] sample_queue[$];
	window_result_t      expected_windows[$];
	window_result_t      want;

	bit  gaps_on;
	bit  sample_beat;
	int  send_gap;
	int  stall_left;
	int  error_count;
	int  results_seen;
	int  clipped_windows;
	int  items_total;
	int  stream_pos;
	int  cycle_count;

	// Source shape of the current phase
	source_kind_t        src_kind;
	int                  tone_a;
	int                  tone_b;
	logic [3:0]          square_mask;

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	function automatic int group_limit(input logic [WINDOW_W-1:0] w);
		if (w == '0)
			return 1;
		if (w > MAX_GROUPS)
			return MAX_GROUPS;
		return int'(w);
	endfunction

	function automatic logic signed [SUM_OUT_W-1:0] clip_sum(input int v);
		if (v > SUM_LIMIT)
			v = SUM_LIMIT;
		if (v < -SUM_LIMIT)
			v = -SUM_LIMIT;
		return v[SUM_OUT_W-1:0];
	endfunction

	// Root of ((I>>3)^2 + (Q>>3)^2) >> 8: power-of-two seed, one Newton step
	function automatic logic [MAG_W-1:0] estimate_magnitude(input int i_acc, input int q_acc);
		longint ti;
		longint tq;
		longint x;
		longint scan;
		longint root;
		int     len;
		ti = longint'(i_acc) >>> PRE_SHIFT;
		tq = longint'(q_acc) >>> PRE_SHIFT;
		x = (ti * ti + tq * tq) >> POST_SHIFT;
		if (x == 0)
			return '0;
		len = 0;
		scan = x;
		while (scan != 0) begin
			len++;
			scan = scan >> 1;
		end
		root = longint'(1) << (len / 2);
		root = (root + x / root) / 2;
		if (root > MAG_LIMIT)
			root = MAG_LIMIT;
		return root[MAG_W-1:0];
	endfunction

	// Mix one accepted sample and queue a result when the window closes
	function automatic void mix_sample(input logic [SAMPLE_W-1:0] s);
		int t;
		window_result_t r;
		t = int'(s);
		case (mix_phase)
			PH_0: begin
				acc_i += t;
				acc_q += t;
			end
			PH_1: begin
				acc_i -= t;
				acc_q += t;
			end
			PH_2: begin
				acc_i -= t;
				acc_q -= t;
			end
			default: begin
				acc_i += t;
				acc_q -= t;
			end
		endcase
		if (mix_phase != PH_3) begin
			mix_phase = mix_phase + 2'd1;
			return;
		end
		mix_phase = PH_0;
		group_count = group_count + 1'b1;
		if (int'(group_count) < group_limit(window_reg))
			return;
		r.in_phase_sum   = clip_sum(acc_i);
		r.quadrature_sum = clip_sum(acc_q);
		r.magnitude      = estimate_magnitude(acc_i, acc_q);
		if (acc_i > SUM_LIMIT || acc_i < -SUM_LIMIT || acc_q > SUM_LIMIT || acc_q < -SUM_LIMIT)
			clipped_windows++;
		expected_windows.push_back(r);
		acc_i = 0;
		acc_q = 0;
		group_count = '0;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [SAMPLE_W-1:0] next_sample();
		int k;
		int v;
		k = stream_pos % 4;
		// break the pattern now and then
		if (src_kind == SRC_NOISE || $urandom_range(0, 99) < 6)
			return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
		if (src_kind == SRC_SQUARE)
			return square_mask[k] ? SAMPLE_W'((1 << SAMPLE_W) - 1) : '0;
		v = 512 + $urandom_range(0, 8) - 4;
		case (k)
			0: v += tone_a;
			1: v += tone_b;
			2: v -= tone_a;
			default: v -= tone_b;
		endcase
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic push_sample(input logic [SAMPLE_W-1:0] s);
		sample_queue.push_back(s);
		stream_pos++;
		items_total++;
	endtask

	// Wait until every sample went in and every result came out
	task automatic drain();
		do
			@(posedge clk);
		while (sample_queue.size() != 0 || in_bus.valid || expected_windows.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic check_window(input logic [WINDOW_W-1:0] value);
		logic [PDATA_W-1:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= WINDOW_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== PDATA_W'(value)) begin
			$error("window_groups readback: expected %0d, got %0d", value, got);
			error_count++;
		end
	endtask

	task automatic write_window(input logic [WINDOW_W-1:0] value);
		logic [PDATA_W-1:0] word;
		word = $urandom();
		word[WINDOW_W-1:0] = value;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= WINDOW_ADDR;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		window_reg = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		check_window(value);
	endtask

	// Sample driver: hold until the beat, then idle or load the next sample
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_bus.valid && !sample_beat) begin
				// hold the current beat
			end else if (send_gap > 0) begin
				in_bus.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (sample_queue.size() != 0) begin
				in_bus.valid  <= 1'b1;
				in_bus.sample <= sample_queue.pop_front();
				send_gap <= pick_gap();
			end else begin
				in_bus.valid <= 1'b0;
			end
		end
	end

	// Result sink: random stalls on ready
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				out_bus.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_bus.ready <= 1'b1;
				if ($urandom_range(0, 99) < 30)
					stall_left <= pick_gap();
			end
		end
	end

	// Monitor: predict on sample beats, check on result beats
	always @(posedge clk) begin
		if (arst_n) begin
			sample_beat <= in_bus.valid && in_bus.ready;
			if (in_bus.valid && in_bus.ready)
				mix_sample(in_bus.sample);
			if (out_bus.valid && out_bus.ready) begin
				if (expected_windows.size() == 0) begin
					$error("unexpected result beat: I %0d Q %0d magnitude %0d",
						out_bus.in_phase_sum, out_bus.quadrature_sum, out_bus.magnitude);
					error_count++;
				end else begin
					want = expected_windows.pop_front();
					results_seen++;
					if (out_bus.in_phase_sum !== want.in_phase_sum) begin
						$error("in_phase_sum: expected %0d, got %0d",
							want.in_phase_sum, out_bus.in_phase_sum);
						error_count++;
					end
					if (out_bus.quadrature_sum !== want.quadrature_sum) begin
						$error("quadrature_sum: expected %0d, got %0d",
							want.quadrature_sum, out_bus.quadrature_sum);
						error_count++;
					end
					if (out_bus.magnitude !== want.magnitude) begin
						$error("magnitude: expected %0d, got %0d",
							want.magnitude, out_bus.magnitude);
						error_count++;
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		logic [WINDOW_W-1:0] corner_windows[9];
		logic [3:0]          masks[4];
		logic [WINDOW_W-1:0] w;
		int                  phase_count;
		int                  span;
		int                  n;

		corner_windows = '{7'd0, 7'd127, 7'd64, 7'd2, 7'd65, 7'd3, 7'd1, 7'd100, 7'd5};
		masks = '{4'b1001, 4'b0011, 4'b0110, 4'b1100};

		in_bus.valid   = 1'b0;
		in_bus.sample  = '0;
		out_bus.ready  = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		window_reg     = WINDOW_W'(WINDOW_RESET);
		acc_i          = 0;
		acc_q          = 0;
		mix_phase      = PH_0;
		group_count    = '0;
		gaps_on        = 1'b1;
		sample_beat    = 1'b0;
		send_gap       = 0;
		stall_left     = 0;
		error_count    = 0;
		results_seen   = 0;
		clipped_windows = 0;
		items_total    = 0;
		stream_pos     = 0;
		cycle_count    = 0;
		src_kind       = SRC_NOISE;
		tone_a         = 0;
		tone_b         = 0;
		square_mask    = '0;

		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(posedge clk);

		check_window(WINDOW_W'(WINDOW_RESET));

		// Directed: one group per window, full-scale patterns and a flat input
		write_window(7'd1);
		for (int k = 0; k < 4; k++)
			push_sample(10'd5);
		for (int g = 0; g < 4; g++)
			for (int k = 0; k < 4; k++)
				push_sample(masks[g][k] ? 10'd1023 : 10'd0);
		for (int k = 0; k < 4; k++)
			push_sample(10'd1023);
		drain();

		// Random phases, each with its own window setting and source shape
		phase_count = 0;
		while (items_total < ITEM_TARGET) begin
			if (phase_count < $size(corner_windows))
				w = corner_windows[phase_count];
			else if ($urandom_range(0, 99) < 70)
				w = WINDOW_W'($urandom_range(1, 6));
			else
				w = WINDOW_W'($urandom_range(0, 127));
			write_window(w);
			span = group_limit(w) * 4;
			gaps_on = (phase_count % 4 != 1);

			if (group_limit(w) >= 16 && (phase_count < $size(corner_windows)
					|| $urandom_range(0, 99) < 50))
				src_kind = SRC_SQUARE;
			else
				src_kind = source_kind_t'($urandom_range(0, 2));
			tone_a = $urandom_range(0, 1022) - 511;
			tone_b = $urandom_range(0, 1022) - 511;
			square_mask = ($urandom_range(0, 3) == 0) ? 4'($urandom()) :
				masks[$urandom_range(0, 3)];

			n = span * $urandom_range(1, group_limit(w) < 8 ? 12 : 2);
			// leave a partial window now and then, carried into the next setting
			if ($urandom_range(0, 3) == 0)
				n += $urandom_range(0, span - 1);
			// stop at the item budget
			if (n > ITEM_TARGET - items_total)
				n = ITEM_TARGET - items_total;
			for (int k = 0; k < n; k++)
				push_sample(next_sample());
			drain();
			phase_count++;
		end

		$display("Checked %0d window results from %0d samples over %0d window settings.",
			results_seen, items_total, phase_count + 1);
		$display("%0d windows had clipped sums; settings 0, 1, 64 and above 64 were included.",
			clipped_windows);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/qrim_pkg.sv
design/qrim_if.sv
design/qrim_regs.sv
design/qrim_mag.sv
design/quarter_rate_iq_magnitude.sv
test/testbench.sv
